[design/assert_macros.svh]
// Assertion helper macros for the square region rotator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SQRR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sqrr check failed");

// next-cycle implication, disabled while reset is low
`define SQRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sqrr check failed");

`endif

[design/sqrr_pkg.sv]
// Shared types and constants for the square region rotator.
// No dependencies; used by the controller, the datapath and the top level.
package sqrr_pkg;

    localparam int ROW_W  = 6;
    localparam int SIZE_W = 7;
    localparam int WORD_W = 32;

    localparam logic [SIZE_W-1:0] GRID_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_ROTATE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_COPY,
        S_GAP,
        S_BACK,
        S_FLUSH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic wr_cell;
        logic rd_cell;
        logic rot_start;
        logic copy_step;
        logic back_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] action;
        logic       cell_ok;
        logic       rot_ok;
        logic       last;
    } t_stat;

endpackage

[design/sqrr_ctrl.sv]
// Controller state machine: sequences clear, cell access and the two rotate passes.
// Depends on sqrr_pkg; drives the datapath through t_cmd, reads t_stat.
module sqrr_ctrl
    import sqrr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;
    logic   ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        ready   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                ready = 1'b1;
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                case (i_stat.action)
                    ACT_WRITE: begin
                        if (i_stat.cell_ok) cmd.wr_cell = 1'b1;
                    end
                    ACT_READ: begin
                        if (i_stat.cell_ok) begin
                            cmd.rd_cell = 1'b1;
                            n_state     = S_RDWAIT;
                        end
                    end
                    ACT_ROTATE: begin
                        if (i_stat.rot_ok) begin
                            cmd.rot_start = 1'b1;
                            n_state       = S_COPY;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDWAIT: n_state = S_RESP;
            S_COPY: begin
                cmd.copy_step = 1'b1;
                if (i_stat.last) n_state = S_GAP;
            end
            S_GAP: begin
                // last scratch write lands here, before any scratch read
                cmd.rot_start = 1'b1;
                n_state       = S_BACK;
            end
            S_BACK: begin
                cmd.back_step = 1'b1;
                if (i_stat.last) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_RESP;
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (cmd.load_out) n_out_valid = 1'b1;
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = ready;
    assign o_out_valid = r_out_valid;

endmodule

[design/sqrr_dp.sv]
// Datapath: config registers, request latch, grid and scratch memories,
// rotate counters and result register. Depends on sqrr_pkg.
module sqrr_dp
    import sqrr_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_index,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    input  logic [1:0]               i_action,
    input  logic [ROW_W-1:0]         i_top_row,
    input  logic [ROW_W-1:0]         i_left_col,
    input  logic [SIZE_W-1:0]        i_square_size,
    input  logic                     i_direction,
    input  logic signed [WORD_W-1:0] i_cell_value,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic                     o_status
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int IW    = (RW > CW) ? RW : CW;
    localparam int SW    = ((IW > ROW_W) ? IW : ROW_W) + 1;
    localparam int EW    = SIZE_W + 1;

    logic [SIZE_W-1:0] r_grid_rows, r_grid_cols;

    logic [1:0]               r_action;
    logic [ROW_W-1:0]         r_top, r_left;
    logic [SIZE_W-1:0]        r_side;
    logic                     r_ccw;
    logic signed [WORD_W-1:0] r_value;

    logic [VALUE_BITS-1:0] r_grid [DEPTH];
    logic [VALUE_BITS-1:0] r_scr  [DEPTH];
    logic [VALUE_BITS-1:0] r_grid_rdata, r_scr_rdata;

    logic [AW-1:0] r_clr_addr;
    logic [IW-1:0] r_i, r_j;
    logic          r_pend_cp, r_pend_bk;
    logic [AW-1:0] r_pend_addr;

    logic signed [WORD_W-1:0] r_out_value;
    logic                     r_out_status;

    logic [SIZE_W-1:0]     rows_use, cols_use;
    logic                  cell_ok, rot_ok, bad, last;
    logic [IW-1:0]         side_m1;
    logic [SW-1:0]         row_sum, col_sum;
    logic [AW-1:0]         cell_addr, rot_addr, scr_dst, scr_src;
    logic                  grid_we, grid_re;
    logic [AW-1:0]         grid_waddr, grid_raddr;
    logic [VALUE_BITS-1:0] grid_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_RESET;
            r_grid_cols <= GRID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS: r_grid_rows <= i_cfg_data;
                CFG_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_top    <= i_top_row;
            r_left   <= i_left_col;
            r_side   <= i_square_size;
            r_ccw    <= i_direction;
            r_value  <= i_cell_value;
        end
    end

    always_comb begin
        rows_use = (int'(r_grid_rows) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : r_grid_rows;
        cols_use = (int'(r_grid_cols) > MAX_COLS) ? SIZE_W'(MAX_COLS) : r_grid_cols;
        cell_ok  = ({1'b0, r_top} < rows_use) && ({1'b0, r_left} < cols_use);
        rot_ok   = (r_side != '0)
                && (EW'(r_top) + EW'(r_side) <= EW'(rows_use))
                && (EW'(r_left) + EW'(r_side) <= EW'(cols_use));
        bad      = ((r_action == ACT_WRITE || r_action == ACT_READ) && !cell_ok)
                || (r_action == ACT_ROTATE && !rot_ok);
        side_m1  = IW'(r_side - 7'd1);
        last     = (r_i == side_m1) && (r_j == side_m1);
        row_sum  = SW'(r_top) + SW'(r_i);
        col_sum  = SW'(r_left) + SW'(r_j);
        cell_addr = {RW'(r_top), CW'(r_left)};
        rot_addr  = {RW'(row_sum), CW'(col_sum)};
        if (r_ccw) scr_dst = {RW'(side_m1 - r_j), CW'(r_i)};
        else       scr_dst = {RW'(r_j), CW'(side_m1 - r_i)};
        scr_src  = {RW'(r_i), CW'(r_j)};
    end

    always_comb begin
        grid_we    = 1'b0;
        grid_waddr = cell_addr;
        grid_wdata = VALUE_BITS'(r_value);
        if (i_cmd.clr_step) begin
            grid_we    = 1'b1;
            grid_waddr = r_clr_addr;
            grid_wdata = '0;
        end else if (i_cmd.wr_cell) begin
            grid_we    = 1'b1;
        end else if (r_pend_bk) begin
            grid_we    = 1'b1;
            grid_waddr = r_pend_addr;
            grid_wdata = r_scr_rdata;
        end
        grid_re    = i_cmd.rd_cell || i_cmd.copy_step;
        grid_raddr = i_cmd.copy_step ? rot_addr : cell_addr;
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) r_grid[grid_waddr] <= grid_wdata;
        if (grid_re) r_grid_rdata <= r_grid[grid_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_cp) r_scr[r_pend_addr] <= r_grid_rdata;
        if (i_cmd.back_step) r_scr_rdata <= r_scr[scr_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pend_cp  <= 1'b0;
            r_pend_bk  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            r_pend_cp <= i_cmd.copy_step;
            r_pend_bk <= i_cmd.back_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= i_cmd.copy_step ? scr_dst : rot_addr;
        if (i_cmd.rot_start) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.copy_step || i_cmd.back_step) begin
            if (r_j == side_m1) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= bad;
            r_out_value  <= (r_action == ACT_READ && cell_ok) ? WORD_W'(r_grid_rdata) : '0;
        end
    end

    assign o_stat.clr_last = &r_clr_addr;
    assign o_stat.action   = r_action;
    assign o_stat.cell_ok  = cell_ok;
    assign o_stat.rot_ok   = rot_ok;
    assign o_stat.last     = last;
    assign o_read_value    = r_out_value;
    assign o_status        = r_out_status;

endmodule

[design/square_region_rotator_core.sv]
// Each request passes a decode and a response state; a read also waits for the
// registered grid read, and a rotate copies the square into scratch and back.
// One request is in flight at a time: the controller takes one only when idle.
// A new request is taken the cycle after the result is loaded, even if unread.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS entries (power-of-two
// padded) zeroes the grid; no request is taken meanwhile, config writes are.
module square_region_rotator_core
    import sqrr_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic [ROW_W-1:0]         i_top_row,
    input  logic [ROW_W-1:0]         i_left_col,
    input  logic [SIZE_W-1:0]        i_square_size,
    input  logic                     i_direction,
    input  logic signed [WORD_W-1:0] i_cell_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic                     o_status
);

`include "assert_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sqrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sqrr_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_top_row     (i_top_row),
        .i_left_col    (i_left_col),
        .i_square_size (i_square_size),
        .i_direction   (i_direction),
        .i_cell_value  (i_cell_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    `SQRR_ASSERT_NOW(a_no_req_in_clear, i_clk, i_rst_n, cmd.clr_step, !o_in_ready)
    `SQRR_ASSERT_NOW(a_no_req_in_rotate, i_clk, i_rst_n,
                     cmd.copy_step || cmd.back_step, !o_in_ready)
    `SQRR_ASSERT_NOW(a_load_into_free_slot, i_clk, i_rst_n, cmd.load_out,
                     !o_out_valid || i_out_ready)
    `SQRR_ASSERT_NEXT(a_refused_reads_zero, i_clk, i_rst_n, cmd.load_out,
                      !o_status || o_read_value == '0)

endmodule

[verif/sqrr_result_checker.sv]
// Result checker for square_region_rotator_core: tracks the grid and the bounds registers,
// predicts each request's result and compares it with what the block returns.
// Depends on sqrr_pkg for the field widths, action codes and register indexes.
`timescale 1ns / 1ps

module sqrr_result_checker
    import sqrr_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_action,
    input  logic [ROW_W-1:0]  i_top_row,
    input  logic [ROW_W-1:0]  i_left_col,
    input  logic [SIZE_W-1:0] i_square_size,
    input  logic              i_direction,
    input  logic [WORD_W-1:0] i_cell_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_read_value,
    input  logic              i_status,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              status;
    } t_cell_result;

    logic [WORD_W-1:0] grid_model [CELLS];
    logic [WORD_W-1:0] turned [CELLS];
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    t_cell_result      awaited_results [$];
    int                fails = 0;
    int                checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void turn_region(input int top, input int left, input int side,
                                        input logic ccw);
        logic [WORD_W-1:0] v;
        for (int i = 0; i < side; i++) begin
            for (int j = 0; j < side; j++) begin
                v = grid_model[(top + i) * MAX_COLS + left + j];
                if (!ccw) begin
                    turned[j * MAX_COLS + side - 1 - i] = v;
                end else begin
                    turned[(side - 1 - j) * MAX_COLS + i] = v;
                end
            end
        end
        for (int i = 0; i < side; i++) begin
            for (int j = 0; j < side; j++) begin
                grid_model[(top + i) * MAX_COLS + left + j] = turned[i * MAX_COLS + j];
            end
        end
    endfunction

    function automatic t_cell_result run_request(input logic [1:0] act,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] col,
                                                 input logic [SIZE_W-1:0] side,
                                                 input logic ccw,
                                                 input logic [WORD_W-1:0] val);
        t_cell_result res;
        int           rows_lim;
        int           cols_lim;
        int           r;
        int           c;
        int           s;
        rows_lim   = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        cols_lim   = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        r          = int'(row);
        c          = int'(col);
        s          = int'(side);
        res.value  = '0;
        res.status = 1'b0;
        case (act)
            ACT_WRITE, ACT_READ: begin
                if (r < rows_lim && c < cols_lim) begin
                    if (act == ACT_WRITE) begin
                        grid_model[r * MAX_COLS + c] = val;
                    end else begin
                        res.value = grid_model[r * MAX_COLS + c];
                    end
                end else begin
                    res.status = 1'b1;
                end
            end
            ACT_ROTATE: begin
                if (s != 0 && r + s <= rows_lim && c + s <= cols_lim) begin
                    turn_region(r, c, s, ccw);
                end else begin
                    res.status = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result predicted;
        t_cell_result oldest;
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) grid_model[k] = '0;
            rows_reg = GRID_RESET;
            cols_reg = GRID_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROWS) begin
                    rows_reg = i_cfg_data;
                end else begin
                    cols_reg = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: read_value %h status %b",
                           i_read_value, i_status);
                    fails++;
                end else begin
                    oldest = awaited_results.pop_front();
                    checked++;
                    if (i_read_value !== oldest.value) begin
                        $error("read_value: expected %h, got %h", oldest.value, i_read_value);
                        fails++;
                    end
                    if (i_status !== oldest.status) begin
                        $error("status: expected %b, got %b", oldest.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted = run_request(i_action, i_top_row, i_left_col, i_square_size,
                                        i_direction, i_cell_value);
                awaited_results.push_back(predicted);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
    end

endmodule

[verif/tb_square_region_rotator_core.sv]
// Testbench top for square_region_rotator_core: resets the block, sets the grid bounds,
// sends directed and random write, rotate and read requests, and gives the verdict.
// Depends on sqrr_pkg, the block itself and sqrr_result_checker.
`timescale 1ns / 1ps

module tb_square_region_rotator_core;
    import sqrr_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 40000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         HOLD_AFTER  = 45;
    localparam int         TAIL_CYCLES = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_action;
    logic [ROW_W-1:0]  i_top_row;
    logic [ROW_W-1:0]  i_left_col;
    logic [SIZE_W-1:0] i_square_size;
    logic              i_direction;
    logic [WORD_W-1:0] i_cell_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [WORD_W-1:0] o_read_value;
    logic              o_status;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles = 0;
    int burst_left = 0;
    int n_write = 0;
    int n_read = 0;
    int n_rotate = 0;
    int n_unused = 0;
    int n_settings = 0;
    int rows_now = 64;
    int cols_now = 64;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    square_region_rotator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_top_row     (i_top_row),
        .i_left_col    (i_left_col),
        .i_square_size (i_square_size),
        .i_direction   (i_direction),
        .i_cell_value  (i_cell_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    sqrr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_top_row     (i_top_row),
        .i_left_col    (i_left_col),
        .i_square_size (i_square_size),
        .i_direction   (i_direction),
        .i_cell_value  (i_cell_value),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_read_value  (o_read_value),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // watchdog: cycles with no accepted request, result or register write
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stretches of ready patterns, one long hold-off
    initial begin
        int   mode;
        int   len;
        logic held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            if (!held && checked >= HOLD_AFTER) begin
                held = 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            for (int k = 0; k < len; k++) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= 1'b0;
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col, input logic [SIZE_W-1:0] side,
                             input logic dir, input logic [WORD_W-1:0] val);
        int gap;
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_top_row     <= row;
        i_left_col    <= col;
        i_square_size <= side;
        i_direction   <= dir;
        i_cell_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
        case (act)
            ACT_WRITE:  n_write++;
            ACT_READ:   n_read++;
            ACT_ROTATE: n_rotate++;
            default:    n_unused++;
        endcase
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 8);
            gap        = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_bounds(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        rows_now = (rows > 64) ? 64 : int'(rows);
        cols_now = (cols > 64) ? 64 : int'(cols);
        n_settings++;
    endtask

    task automatic random_item(input int win);
        logic [1:0]        act;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [SIZE_W-1:0] side;
        logic              dir;
        logic [WORD_W-1:0] val;
        int                roll;
        row  = $urandom;
        col  = $urandom;
        side = $urandom;
        dir  = $urandom;
        val  = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            act = ACT_WRITE;
        end else if (roll < 65) begin
            act = ACT_READ;
        end else if (roll < 95) begin
            act = ACT_ROTATE;
        end else begin
            act = ACT_UNUSED;
        end
        if (act == ACT_ROTATE) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                side = $urandom_range(1, win);
                row  = $urandom_range(0, win - side);
                col  = $urandom_range(0, win - side);
            end else if (roll < 84) begin
                side = $urandom_range(9, 64);
                row  = $urandom_range(0, 64 - side);
                col  = $urandom_range(0, 64 - side);
            end
        end else if ($urandom_range(0, 3) != 0) begin
            row = $urandom_range(0, win - 1);
            col = $urandom_range(0, win - 1);
        end
        send_item(act, row, col, side, dir, val);
    endtask

    initial begin
        int win;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_ROWS;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_WRITE;
        i_top_row     <= '0;
        i_left_col    <= '0;
        i_square_size <= '0;
        i_direction   <= 1'b0;
        i_cell_value  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bounds: corners, value extremes, both turns, refused squares
        send_item(ACT_WRITE, 0, 0, 1, 0, 32'h7fff_ffff);
        send_item(ACT_WRITE, 0, 1, 1, 1, 32'h8000_0000);
        send_item(ACT_WRITE, 1, 0, 1, 0, 32'hffff_ffff);
        send_item(ACT_WRITE, 63, 63, 1, 0, 32'ha5a5_5a5a);
        send_item(ACT_READ, 63, 63, 0, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 0, 2, 0, 32'h0);
        send_item(ACT_READ, 0, 1, 0, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 0, 2, 1, 32'h0);
        send_item(ACT_ROTATE, 0, 0, 64, 1, 32'h0);
        send_item(ACT_READ, 63, 0, 0, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 0, 0, 0, 32'h0);
        send_item(ACT_ROTATE, 1, 0, 64, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 1, 64, 1, 32'h0);
        send_item(ACT_ROTATE, 0, 0, 127, 0, 32'h0);
        send_item(ACT_UNUSED, 63, 63, 127, 1, 32'hffff_ffff);
        wait_idle();

        set_bounds(3, 5);
        send_item(ACT_WRITE, 3, 0, 1, 0, 32'h1234_5678);
        send_item(ACT_WRITE, 2, 4, 1, 0, 32'h0bad_cafe);
        send_item(ACT_READ, 0, 5, 0, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 2, 3, 0, 32'h0);
        send_item(ACT_ROTATE, 0, 3, 3, 1, 32'h0);
        send_item(ACT_READ, 2, 2, 0, 0, 32'h0);
        wait_idle();

        // zero bounds refuse everything
        set_bounds(0, 0);
        send_item(ACT_WRITE, 0, 0, 1, 0, 32'h5555_5555);
        send_item(ACT_ROTATE, 0, 0, 1, 0, 32'h0);
        wait_idle();

        // above the maximum acts as full size
        set_bounds(127, 127);
        send_item(ACT_ROTATE, 1, 1, 63, 0, 32'h0);
        send_item(ACT_READ, 63, 63, 0, 0, 32'h0);
        wait_idle();

        set_bounds(1, 1);
        send_item(ACT_ROTATE, 0, 0, 1, 1, 32'h0);
        send_item(ACT_READ, 0, 1, 0, 0, 32'h0);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_bounds(64, 64);
                1: set_bounds($urandom_range(4, 12), $urandom_range(4, 12));
                2: set_bounds(1, 64);
                3: set_bounds(64, 1);
                4: set_bounds($urandom_range(0, 127), $urandom_range(0, 127));
                default: set_bounds($urandom_range(65, 127), $urandom_range(1, 64));
            endcase
            win = (rows_now < cols_now) ? rows_now : cols_now;
            if (win > 8) win = 8;
            if (win < 1) win = 1;
            for (int k = 0; k < 12; k++) begin
                random_item(win);
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results: %0d writes, %0d reads, %0d rotates, %0d unused actions",
                 checked, n_write, n_read, n_rotate, n_unused);
        $display("Grid bounds changed %0d times, from zero through full size and above it",
                 n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
